// ===== src/swma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median alert: shared package
// Field widths, default sizes, controller states and the status record that
// the median scan unit hands back to the controller.
// ----------------------------------------------------------------------------
package swma_pkg;

    // Default sizes for the top-level parameters.
    localparam int BINS_DEF       = 256;
    localparam int MAX_WINDOW_DEF = 1024;

    // Fixed field widths.
    localparam int SAMPLE_W    = 8;
    localparam int COUNT_W     = 11;
    localparam int CFG_W       = 11;
    localparam int DM_W        = 9;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DM_W - 1 - TOTAL_W;

    // Window length after reset.
    localparam logic [CFG_W-1:0] WLEN_RESET = CFG_W'(5);

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEC_RD,
        S_DEC_WR,
        S_INC_RD,
        S_INC_WR,
        S_OUT
    } t_state;

    // Status from the median scan unit.
    typedef struct packed {
        logic            done;
        logic [DM_W-1:0] dm;
    } t_scan_stat;

endpackage

// ===== src/swma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swma_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/swma_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median alert: median scan unit
// Walks the histogram memory one bin per cycle, accumulating counts to find
// the lower middle bin and, for an even window that splits exactly, the next
// occupied bin. Returns twice the median.
// ----------------------------------------------------------------------------
module swma_scan #(
    parameter int  BINS       = swma_pkg::BINS_DEF,
    parameter int  MAX_WINDOW = swma_pkg::MAX_WINDOW_DEF,
    localparam int BIN_AW     = $clog2(BINS),
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_odd,
    input  logic [CNT_W-1:0]              i_target,
    input  logic [swma_pkg::COUNT_W-1:0]  i_count,
    output logic                          o_rd_en,
    output logic [BIN_AW-1:0]             o_rd_addr,
    output swma_pkg::t_scan_stat          o_stat
);

    import swma_pkg::*;

    localparam int SUM_W = COUNT_W + BIN_AW;
    localparam int ACC_W = (SUM_W > CNT_W) ? SUM_W : CNT_W;
    localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(BINS - 1);

    logic              r_busy;
    logic [BIN_AW-1:0] r_issue_addr;
    logic              r_issue_end;
    logic              r_dvld;
    logic [BIN_AW-1:0] r_daddr;
    logic [ACC_W-1:0]  r_acc;
    logic              r_hi_phase;
    logic [BIN_AW-1:0] r_lo;
    logic              r_odd;
    logic [CNT_W-1:0]  r_target;
    logic              r_done;
    logic [DM_W-1:0]   r_dm;

    logic [ACC_W-1:0]  w_acc_sum;
    logic              w_hit;
    logic              w_over;
    logic              w_last;
    logic              w_fin;
    logic              w_go_hi;
    logic [DM_W-1:0]   w_dm;

    // Read issue: one bin per cycle until the last bin has been requested.
    assign o_rd_en   = r_busy && !r_issue_end;
    assign o_rd_addr = r_issue_addr;

    // Evaluate the count that returns for the bin read in the previous cycle.
    always_comb begin
        w_acc_sum = r_acc + ACC_W'(i_count);
        w_hit     = w_acc_sum >= ACC_W'(r_target);
        w_over    = w_acc_sum > ACC_W'(r_target);
        w_last    = r_daddr == LAST_BIN;
        w_fin     = 1'b0;
        w_go_hi   = 1'b0;
        w_dm      = '0;
        if (r_dvld) begin
            if (!r_hi_phase) begin
                if (w_hit) begin
                    if (w_over || r_odd || w_last) begin
                        w_fin = 1'b1;
                        w_dm  = DM_W'(32'(r_daddr) + 32'(r_daddr));
                    end else begin
                        w_go_hi = 1'b1;
                    end
                end else if (w_last) begin
                    w_fin = 1'b1;
                    w_dm  = DM_W'(32'(r_daddr) + 32'(r_daddr));
                end
            end else begin
                if (i_count != '0) begin
                    w_fin = 1'b1;
                    w_dm  = DM_W'(32'(r_lo) + 32'(r_daddr));
                end else if (w_last) begin
                    w_fin = 1'b1;
                    w_dm  = DM_W'(32'(r_lo) + 32'(r_lo));
                end
            end
        end
    end

    // Control state of the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dvld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_fin;
            if (i_start) begin
                r_busy <= 1'b1;
                r_dvld <= 1'b0;
            end else if (r_busy) begin
                if (w_fin) begin
                    r_busy <= 1'b0;
                    r_dvld <= 1'b0;
                end else begin
                    r_dvld <= o_rd_en;
                end
            end
        end
    end

    // Scan datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_issue_addr <= '0;
            r_issue_end  <= 1'b0;
            r_acc        <= '0;
            r_hi_phase   <= 1'b0;
            r_odd        <= i_odd;
            r_target     <= i_target;
        end else if (r_busy) begin
            if (o_rd_en) begin
                r_issue_end <= r_issue_addr == LAST_BIN;
                if (r_issue_addr != LAST_BIN) begin
                    r_issue_addr <= r_issue_addr + BIN_AW'(1);
                end
            end
            r_daddr <= r_issue_addr;
            if (r_dvld && !r_hi_phase) begin
                r_acc <= w_acc_sum;
            end
            if (w_go_hi) begin
                r_hi_phase <= 1'b1;
                r_lo       <= r_daddr;
            end
        end
        if (w_fin) begin
            r_dm <= w_dm;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.dm   = r_dm;

endmodule

// ===== src/sliding_window_median_alert.sv =====
`timescale 1ns / 1ps
// A sample that only fills the window is counted into its bin and gives no beat.
// On a full window the median scan runs first and stops at the median bin; then the
// oldest sample leaves its bin, the new one is counted and the beat is registered.
// Samples are taken one at a time: a new one is accepted only once the last is done.
// Reset (synchronous, active low) sets the window length to 5, empties the
// histogram through per-bin valid bits and clears the alert count at once.
// ----------------------------------------------------------------------------
// Sliding window median alert: top level
// Keeps a ring of recent samples and a count histogram in two RAMs, finds the
// doubled median of the window by a histogram scan and flags samples that
// reach it, with a saturating alert count.
// ----------------------------------------------------------------------------
module sliding_window_median_alert #(
    parameter int BINS       = swma_pkg::BINS_DEF,
    parameter int MAX_WINDOW = swma_pkg::MAX_WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: window length.
    input  logic                              i_cfg_wr_en,
    input  logic [swma_pkg::CFG_W-1:0]        i_cfg_wr_data,
    // Sample stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [swma_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] sample
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [8:0] doubled_median, [9] alert, [41:10] alert_total, [47:42] zero
    output logic [swma_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import swma_pkg::*;

    localparam int BIN_AW  = $clog2(BINS);
    localparam int HIST_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Map a sample to its histogram bin, clamping to the top bin.
    function automatic logic [BIN_AW-1:0] f_bin(input logic [SAMPLE_W-1:0] s);
        if (32'(s) >= 32'(BINS)) begin
            f_bin = BIN_AW'(BINS - 1);
        end else begin
            f_bin = BIN_AW'(s);
        end
    endfunction

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_wlen;
    logic [CNT_W-1:0]     r_fill;
    logic [HIST_AW-1:0]   r_ptr;
    logic [TOTAL_W-1:0]   r_total;
    logic [BINS-1:0]      r_bin_vld;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [BIN_AW-1:0]    r_bin;
    logic                 r_emit;
    logic [DM_W-1:0]      r_dm;
    logic                 r_rd_vld;
    logic [BIN_AW-1:0]    r_rd_addr;
    logic                 r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [31:0]          w_wl32;
    logic [CNT_W-1:0]     w_n;
    logic [CNT_W-1:0]     w_target;
    logic                 w_accept;
    logic                 w_filling;
    logic [COUNT_W-1:0]   w_cnt;
    logic                 w_alert;
    logic [TOTAL_W-1:0]   w_total;
    logic                 w_load;

    // Bin RAM ports.
    logic                 w_bin_we;
    logic [BIN_AW-1:0]    w_bin_waddr;
    logic [COUNT_W-1:0]   w_bin_wdata;
    logic                 w_bin_re;
    logic [BIN_AW-1:0]    w_bin_raddr;
    logic [COUNT_W-1:0]   w_bin_rdata;

    // History RAM ports.
    logic                 w_hist_we;
    logic [HIST_AW-1:0]   w_hist_waddr;
    logic                 w_hist_re;
    logic [SAMPLE_W-1:0]  w_hist_rdata;

    // Scan unit interface.
    logic                 w_scan_start;
    logic                 w_scan_re;
    logic [BIN_AW-1:0]    w_scan_addr;
    t_scan_stat           w_scan_stat;

    // Effective window length, clamped to 1..MAX_WINDOW, and the scan target.
    always_comb begin
        w_wl32 = 32'(r_wlen);
        if (r_wlen == '0) begin
            w_n = CNT_W'(1);
        end else if (w_wl32 > 32'(MAX_WINDOW)) begin
            w_n = CNT_W'(MAX_WINDOW);
        end else begin
            w_n = CNT_W'(w_wl32);
        end
        w_target = (w_n >> 1) + CNT_W'(w_n[0]);
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_filling     = r_fill < w_n;

    // Count returned by the bin RAM; a bin not written since clear reads zero.
    assign w_cnt = r_rd_vld ? w_bin_rdata : '0;

    // Result of the current sample.
    assign w_alert = {1'b0, r_sample} >= r_dm;
    assign w_total = (w_alert && r_total != TOTAL_MAX) ? r_total + TOTAL_W'(1) : r_total;
    assign w_load  = (r_state == S_OUT) && (!r_out_vld || m_axis_tready);

    // Next state and memory control.
    always_comb begin
        n_state      = r_state;
        w_bin_we     = 1'b0;
        w_bin_waddr  = r_rd_addr;
        w_bin_wdata  = '0;
        w_bin_re     = 1'b0;
        w_bin_raddr  = r_bin;
        w_hist_we    = 1'b0;
        w_hist_waddr = r_ptr;
        w_hist_re    = 1'b0;
        w_scan_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_filling) begin
                        w_bin_re     = 1'b1;
                        w_bin_raddr  = f_bin(s_axis_tdata[SAMPLE_W-1:0]);
                        w_hist_we    = 1'b1;
                        w_hist_waddr = HIST_AW'(r_fill);
                        n_state      = S_INC_WR;
                    end else begin
                        w_hist_re    = 1'b1;
                        w_scan_start = 1'b1;
                        n_state      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_bin_re    = w_scan_re;
                w_bin_raddr = w_scan_addr;
                if (w_scan_stat.done) begin
                    n_state = S_DEC_RD;
                end
            end
            S_DEC_RD: begin
                // Oldest sample leaves; the new sample takes its ring slot.
                w_bin_re    = 1'b1;
                w_bin_raddr = f_bin(w_hist_rdata);
                w_hist_we   = 1'b1;
                n_state     = S_DEC_WR;
            end
            S_DEC_WR: begin
                w_bin_we    = w_cnt != '0;
                w_bin_wdata = w_cnt - COUNT_W'(1);
                n_state     = S_INC_RD;
            end
            S_INC_RD: begin
                w_bin_re = 1'b1;
                n_state  = S_INC_WR;
            end
            S_INC_WR: begin
                w_bin_we    = 1'b1;
                w_bin_wdata = w_cnt + COUNT_W'(1);
                n_state     = r_emit ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window control: length, fill level, ring pointer and bin valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= WLEN_RESET;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_bin_vld <= '0;
        end else if (i_cfg_wr_en) begin
            r_wlen    <= i_cfg_wr_data;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_bin_vld <= '0;
        end else begin
            if (w_accept && w_filling) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (r_state == S_DEC_RD) begin
                if (32'(r_ptr) + 32'd1 == 32'(w_n)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + HIST_AW'(1);
                end
            end
            if (w_bin_we) begin
                r_bin_vld[w_bin_waddr] <= 1'b1;
            end
        end
    end

    // Per-sample payload and read tracking.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= s_axis_tdata[SAMPLE_W-1:0];
            r_bin    <= f_bin(s_axis_tdata[SAMPLE_W-1:0]);
            r_emit   <= !w_filling;
        end
        if (w_bin_re) begin
            r_rd_vld  <= r_bin_vld[w_bin_raddr];
            r_rd_addr <= w_bin_raddr;
        end
        if (w_scan_stat.done) begin
            r_dm <= w_scan_stat.dm;
        end
    end

    // Alert count, kept across window restarts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_load) begin
            r_total <= w_total;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {OUT_PAD_W'(0), w_total, w_alert, r_dm};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Histogram of the window.
    swma_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BINS)
    ) u_bin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_bin_we),
        .i_wr_addr (w_bin_waddr),
        .i_wr_data (w_bin_wdata),
        .i_rd_en   (w_bin_re),
        .i_rd_addr (w_bin_raddr),
        .o_rd_data (w_bin_rdata)
    );

    // Ring of window samples.
    swma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_hist_we),
        .i_wr_addr (w_hist_waddr),
        .i_wr_data (r_state == S_IDLE ? s_axis_tdata[SAMPLE_W-1:0] : r_sample),
        .i_rd_en   (w_hist_re),
        .i_rd_addr (r_ptr),
        .o_rd_data (w_hist_rdata)
    );

    // Median scan over the histogram.
    swma_scan #(
        .BINS       (BINS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_scan_start),
        .i_odd     (w_n[0]),
        .i_target  (w_target),
        .i_count   (w_cnt),
        .o_rd_en   (w_scan_re),
        .o_rd_addr (w_scan_addr),
        .o_stat    (w_scan_stat)
    );

endmodule

// ===== src/swma_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median alert: port checker
// Watches the top-level ports and checks output hold, padding, sample-at-a-
// time operation and the saturating alert count across beats.
// ----------------------------------------------------------------------------
module swma_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_wr_en,
    input logic [swma_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [swma_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [swma_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import swma_pkg::*;

    logic                r_seen;
    logic [TOTAL_W-1:0]  r_last_total;
    logic [TOTAL_W-1:0]  w_total;
    logic                w_alert;
    logic [TOTAL_W-1:0]  w_expect;
    logic                w_out_acc;

    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_total   = m_axis_tdata[DM_W+TOTAL_W:DM_W+1];
    assign w_alert   = m_axis_tdata[DM_W];
    assign w_expect  = (w_alert && r_last_total != '1) ? r_last_total + TOTAL_W'(1)
                                                        : r_last_total;

    // Track the alert count of the last delivered beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_last_total <= '0;
        end else if (w_out_acc) begin
            r_seen       <= 1'b1;
            r_last_total <= w_total;
        end
    end

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // One sample is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while another is in progress");

    // Each beat's count follows the previous one by its alert flag.
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && r_seen |-> w_total == w_expect)
        else $error("alert count does not follow the alert flags");

    // Padding bits above the fields stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:DM_W+TOTAL_W+1] == '0)
        else $error("result padding is not zero");

endmodule

bind sliding_window_median_alert swma_checker u_swma_checker (.*);
